// File: rtl/core/mst_pkg.sv
// mst_pkg: shared constants and types of the multi-slot interval timer
// slot count, opcode, result kind and sequencer state encodings
// no dependencies
package mst_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int TICK_W      = 32;
	localparam int SLOT_W      = 4;
	localparam int ENTRY_W     = 2 * TICK_W;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_DELETE  = 3'd1,
		OP_STOP    = 3'd2,
		OP_ADVANCE = 3'd3,
		OP_PROCESS = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_ADDED   = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_EXPIRED = 3'd3,
		KIND_NONE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/mst_ram.sv
// mst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/multi_slot_interval_timer_top.sv
// multi_slot_interval_timer_top: timer slot table sharing one millisecond tick
// depends on mst_pkg and mst_ram (period and start of each slot)
//
// usage
// input channel in_valid/in_ready carries one command word: opcode, slot,
// period_ms, repeat_req, elapsed_ms. output channel out_valid/out_ready
// carries result words: kind, slot_id, last.
// add, delete, stop and advance are done in the accept cycle; their single
// result word is visible in the next cycle. a new command is taken as soon as
// the output register is free or being drained.
// process walks the slot table one slot per cycle while the output is not
// stalled, reading period and start from the slot ram (registered read) and
// writing back restarts in the same pass.
// expiry words leave in slot order; the final one carries last, or a single
// nothing-expired word is sent.
// a stalled receiver holds the output word; the walk pauses on the next expiry
// until the held word is taken, and no command is taken meanwhile.
// reset clears the tick, all slot valid bits and the sequencer; no clearing
// pass is needed, slot ram entries are used only for valid slots.
module multi_slot_interval_timer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [31:0] period_ms,
	input  logic        repeat_req,
	input  logic [31:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  slot_id,
	output logic        last
);

	mst_pkg::state_t state_q, state_d;

	logic [mst_pkg::NUM_SLOTS-1:0] valid_q, valid_d;
	logic [mst_pkg::NUM_SLOTS-1:0] repeat_q, repeat_d;
	logic [mst_pkg::TICK_W-1:0]    now_q, now_d;
	logic [mst_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic [mst_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic                          pend_valid_q, pend_valid_d;
	logic [mst_pkg::IDX_W-1:0]     pend_slot_q, pend_slot_d;

	logic                          out_valid_q;
	mst_pkg::kind_t                out_kind_q, out_kind_d;
	logic [mst_pkg::SLOT_W-1:0]    out_slot_q, out_slot_d;
	logic                          out_last_q, out_last_d;
	logic                          out_load;
	logic                          out_free;

	logic                          ram_we;
	logic [mst_pkg::IDX_W-1:0]     ram_waddr;
	logic [mst_pkg::ENTRY_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [mst_pkg::IDX_W-1:0]     ram_raddr;
	logic [mst_pkg::ENTRY_W-1:0]   ram_rdata;

	logic [mst_pkg::TICK_W-1:0]    rd_period;
	logic [mst_pkg::TICK_W-1:0]    rd_start;
	logic [mst_pkg::TICK_W-1:0]    age;
	logic                          expired;
	logic                          in_acc;
	logic                          free_found;
	logic [mst_pkg::IDX_W-1:0]     free_idx;
	logic                          slot_ok;
	logic [mst_pkg::IDX_W-1:0]     cmd_idx;

	mst_ram #(
		.WIDTH(mst_pkg::ENTRY_W),
		.DEPTH(mst_pkg::NUM_SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == mst_pkg::ST_IDLE) && out_free;
	assign in_acc    = in_valid && in_ready;
	assign rd_period = ram_rdata[mst_pkg::ENTRY_W-1:mst_pkg::TICK_W];
	assign rd_start  = ram_rdata[mst_pkg::TICK_W-1:0];
	assign age       = now_q - rd_start;
	assign expired   = valid_q[idx_q] && (age >= rd_period);
	assign slot_ok   = int'(slot) < mst_pkg::NUM_SLOTS;
	assign cmd_idx   = mst_pkg::IDX_W'(slot);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = mst_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = mst_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		valid_d      = valid_q;
		repeat_d     = repeat_q;
		now_d        = now_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_slot_d  = pend_slot_q;
		out_load     = 1'b0;
		out_kind_d   = mst_pkg::KIND_ACK;
		out_slot_d   = '0;
		out_last_d   = 1'b1;
		ram_we       = 1'b0;
		ram_waddr    = idx_q;
		ram_wdata    = {rd_period, now_q};
		ram_re       = 1'b0;
		ram_raddr    = mst_pkg::IDX_W'(idx_q + 1'b1);
		case (state_q)
			mst_pkg::ST_IDLE: begin
				if (in_acc) begin
					out_load = 1'b1;
					case (mst_pkg::op_t'(opcode))
						mst_pkg::OP_ADD: begin
							if (free_found) begin
								valid_d[free_idx]  = 1'b1;
								repeat_d[free_idx] = repeat_req;
								ram_we             = 1'b1;
								ram_waddr          = free_idx;
								ram_wdata          = {period_ms, now_q};
								out_kind_d         = mst_pkg::KIND_ADDED;
								out_slot_d         = mst_pkg::SLOT_W'(free_idx);
							end else begin
								out_kind_d = mst_pkg::KIND_FULL;
							end
						end
						mst_pkg::OP_DELETE: begin
							if (slot_ok) begin
								valid_d[cmd_idx] = 1'b0;
							end
						end
						mst_pkg::OP_STOP: begin
							if (slot_ok && valid_q[cmd_idx]) begin
								repeat_d[cmd_idx] = 1'b0;
							end
						end
						mst_pkg::OP_ADVANCE: begin
							now_d = now_q + elapsed_ms;
						end
						mst_pkg::OP_PROCESS: begin
							out_load     = 1'b0;
							ram_re       = 1'b1;
							ram_raddr    = '0;
							idx_d        = '0;
							cnt_d        = '0;
							pend_valid_d = 1'b0;
							state_d      = mst_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			mst_pkg::ST_SCAN: begin
				// pause while a found expiry cannot move the pending word out
				if (!(expired && pend_valid_q && !out_free)) begin
					if (expired) begin
						if (pend_valid_q) begin
							out_load   = 1'b1;
							out_kind_d = mst_pkg::KIND_EXPIRED;
							out_slot_d = mst_pkg::SLOT_W'(pend_slot_q);
							out_last_d = 1'b0;
						end
						pend_valid_d = 1'b1;
						pend_slot_d  = idx_q;
						cnt_d        = mst_pkg::CNT_W'(cnt_q + 1'b1);
						if (repeat_q[idx_q]) begin
							ram_we = 1'b1;
						end else begin
							valid_d[idx_q] = 1'b0;
						end
					end
					if ((idx_q == mst_pkg::IDX_W'(mst_pkg::NUM_SLOTS - 1)) ||
					    (expired && (cnt_q == mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS - 1)))) begin
						state_d = mst_pkg::ST_DONE;
					end else begin
						ram_re = 1'b1;
						idx_d  = mst_pkg::IDX_W'(idx_q + 1'b1);
					end
				end
			end
			mst_pkg::ST_DONE: begin
				if (out_free) begin
					out_load     = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = mst_pkg::ST_IDLE;
					if (pend_valid_q) begin
						out_kind_d = mst_pkg::KIND_EXPIRED;
						out_slot_d = mst_pkg::SLOT_W'(pend_slot_q);
					end else begin
						out_kind_d = mst_pkg::KIND_NONE;
					end
				end
			end
			default: begin
				state_d = mst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mst_pkg::ST_IDLE;
			valid_q      <= '0;
			now_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			valid_q      <= valid_d;
			now_q        <= now_d;
			idx_q        <= idx_d;
			cnt_q        <= cnt_d;
			pend_valid_q <= pend_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		repeat_q    <= repeat_d;
		pend_slot_q <= pend_slot_d;
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_slot_q <= out_slot_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign slot_id   = out_slot_q;
	assign last      = out_last_q;

`ifndef NO_ASSERTIONS
	a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q != mst_pkg::ST_IDLE))
		else $error("pending expiry outside a process walk");

	a_mid_word_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (state_q != mst_pkg::ST_IDLE))
		else $error("non-final word while idle");

	a_no_load_over_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("output word overwritten while stalled");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS))
		else $error("expiry count beyond limit");
`endif

endmodule
